// File: rtl/core/mhr_pkg.sv
package mhr_pkg;

    localparam int MIN_EOL_ZEROS = 11;
    localparam int RTC_EOL_COUNT = 6;
    localparam int EOL_BITS      = 12;
    localparam int QDEPTH        = 4;
    localparam int ENTRIES       = 104;
    localparam int NUM_TERM      = 64;
    localparam int NUM_MAKEUP    = 27;
    localparam int MAX_CODE_LEN  = 13;
    localparam int DOT_MAX       = 8191;

    localparam logic [11:0] LINES_RESET = 12'd2340;
    localparam logic [11:0] WIDTH_RESET = 12'd1728;

    typedef enum logic [1:0] {
        CFG_LINES_PER_PAGE = 2'd0,
        CFG_LINE_WIDTH     = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_NO_EOL    = 2'd1,
        ERR_BAD_CODE  = 2'd2,
        ERR_TOO_LONG  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_DECODE = 2'd1,
        PH_HALT   = 2'd2
    } phase_t;

    // One queued command: an optional copied code bit, then a number of EOLs,
    // then optional zero padding, then an optional status item.
    typedef struct packed {
        logic       has_bit;
        logic       code_bit;
        logic [3:0] eol_count;
        logic       pad;
        err_t       fail;
    } cmd_t;

    typedef struct packed {
        logic        match;
        logic        live;
        logic [11:0] run;
    } lookup_t;

    // Entry is length << 8 | code. Terminating, make-up, extended make-up.
    localparam logic [15:0] WHITE_CODES [ENTRIES] = '{
        16'h0835,16'h0607,16'h0407,16'h0408,16'h040B,16'h040C,16'h040E,16'h040F,
        16'h0513,16'h0514,16'h0507,16'h0508,16'h0608,16'h0603,16'h0634,16'h0635,
        16'h062A,16'h062B,16'h0727,16'h070C,16'h0708,16'h0717,16'h0703,16'h0704,
        16'h0728,16'h072B,16'h0713,16'h0724,16'h0718,16'h0802,16'h0803,16'h081A,
        16'h081B,16'h0812,16'h0813,16'h0814,16'h0815,16'h0816,16'h0817,16'h0828,
        16'h0829,16'h082A,16'h082B,16'h082C,16'h082D,16'h0804,16'h0805,16'h080A,
        16'h080B,16'h0852,16'h0853,16'h0854,16'h0855,16'h0824,16'h0825,16'h0858,
        16'h0859,16'h085A,16'h085B,16'h084A,16'h084B,16'h0832,16'h0833,16'h0834,
        16'h051B,16'h0512,16'h0617,16'h0737,16'h0836,16'h0837,16'h0864,16'h0865,
        16'h0868,16'h0867,16'h09CC,16'h09CD,16'h09D2,16'h09D3,16'h09D4,16'h09D5,
        16'h09D6,16'h09D7,16'h09D8,16'h09D9,16'h09DA,16'h09DB,16'h0998,16'h0999,
        16'h099A,16'h0618,16'h099B,
        16'h0B08,16'h0B0C,16'h0B0D,16'h0C12,16'h0C13,16'h0C14,16'h0C15,
        16'h0C16,16'h0C17,16'h0C1C,16'h0C1D,16'h0C1E,16'h0C1F
    };

    localparam logic [15:0] BLACK_CODES [ENTRIES] = '{
        16'h0A37,16'h0302,16'h0203,16'h0202,16'h0303,16'h0403,16'h0402,16'h0503,
        16'h0605,16'h0604,16'h0704,16'h0705,16'h0707,16'h0804,16'h0807,16'h0918,
        16'h0A17,16'h0A18,16'h0A08,16'h0B67,16'h0B68,16'h0B6C,16'h0B37,16'h0B28,
        16'h0B17,16'h0B18,16'h0CCA,16'h0CCB,16'h0CCC,16'h0CCD,16'h0C68,16'h0C69,
        16'h0C6A,16'h0C6B,16'h0CD2,16'h0CD3,16'h0CD4,16'h0CD5,16'h0CD6,16'h0CD7,
        16'h0C6C,16'h0C6D,16'h0CDA,16'h0CDB,16'h0C54,16'h0C55,16'h0C56,16'h0C57,
        16'h0C64,16'h0C65,16'h0C52,16'h0C53,16'h0C24,16'h0C37,16'h0C38,16'h0C27,
        16'h0C28,16'h0C58,16'h0C59,16'h0C2B,16'h0C2C,16'h0C5A,16'h0C66,16'h0C67,
        16'h0A0F,16'h0CC8,16'h0CC9,16'h0C5B,16'h0C33,16'h0C34,16'h0C35,16'h0D6C,
        16'h0D6D,16'h0D4A,16'h0D4B,16'h0D4C,16'h0D4D,16'h0D72,16'h0D73,16'h0D74,
        16'h0D75,16'h0D76,16'h0D77,16'h0D52,16'h0D53,16'h0D54,16'h0D55,16'h0D5A,
        16'h0D5B,16'h0D64,16'h0D65,
        16'h0B08,16'h0B0C,16'h0B0D,16'h0C12,16'h0C13,16'h0C14,16'h0C15,
        16'h0C16,16'h0C17,16'h0C1C,16'h0C1D,16'h0C1E,16'h0C1F
    };

    // Match the code prefix against every table entry in parallel.
    function automatic lookup_t mhr_lookup(input logic black, input logic [3:0] len,
                                           input logic [12:0] pos);
        lookup_t     res;
        logic [15:0] ent;
        logic [3:0]  elen;
        logic [12:0] ecode;
        res = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ent   = black ? BLACK_CODES[i] : WHITE_CODES[i];
            elen  = ent[11:8];
            ecode = {5'd0, ent[7:0]};
            if (elen == len && ecode == pos)
            begin
                res.match = 1'b1;
                if (i < NUM_TERM)
                    res.run = res.run | 12'(i);
                else if (i < NUM_TERM + NUM_MAKEUP)
                    res.run = res.run | 12'((i - (NUM_TERM - 1)) * 64);
                else
                    res.run = res.run | 12'(1792 + (i - (NUM_TERM + NUM_MAKEUP)) * 64);
            end
            if (elen > len && (ecode >> (elen - len)) == pos)
                res.live = 1'b1;
        end
        if (len == 4'd0 || len > 4'(MAX_CODE_LEN))
        begin
            res.match = 1'b0;
            res.live  = 1'b0;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/mhr_if.sv
interface mhr_bit_if;
    logic valid;
    logic ready;
    logic in_bit;
    modport source (output valid, output in_bit, input ready);
    modport sink (input valid, input in_bit, output ready);
endinterface

interface mhr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       page_done;
    logic [1:0] error_code;
    logic       last_of_run;
    modport source (output valid, output out_byte, output byte_valid, output page_done,
                    output error_code, output last_of_run, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input page_done,
                  input error_code, input last_of_run, output ready);
endinterface

interface mhr_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [11:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/mhr_front.sv
module mhr_front (
    input  logic          clk,
    input  logic          rst_n,
    mhr_bit_if.sink       bits,
    mhr_cfg_if.sink       cfg,
    input  logic          q_full,
    output logic          push,
    output mhr_pkg::cmd_t cmd
);
    import mhr_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  zero_run_reg, zero_run_next;
    logic [12:0] pos_reg, pos_next;
    logic [3:0]  len_reg, len_next;
    logic        black_reg, black_next;
    logic [12:0] dot_reg, dot_next;
    logic [11:0] line_reg, line_next;
    logic [11:0] lines_reg, width_reg;

    logic        acc;
    logic        b;
    logic [12:0] pos_step;
    logic [3:0]  len_step;
    lookup_t     lk;
    logic [13:0] sum;
    logic [12:0] dot_sat;
    logic [11:0] line_inc;
    logic        is_term;
    logic        line_end;
    logic        too_long;
    logic        eol_ok;

    assign bits.ready = !q_full;
    assign cfg.ready  = 1'b1;
    assign acc        = bits.valid && !q_full;
    assign b          = bits.in_bit;

    assign pos_step = {pos_reg[11:0], b};
    assign len_step = len_reg + 4'd1;
    assign lk       = mhr_lookup(black_reg, len_step, pos_step);
    assign sum      = {1'b0, dot_reg} + {2'd0, lk.run};
    assign dot_sat  = (sum > 14'(DOT_MAX)) ? 13'(DOT_MAX) : sum[12:0];
    assign line_inc = line_reg + 12'd1;
    assign is_term  = lk.run < 12'(NUM_TERM);
    assign line_end = is_term && dot_sat >= {1'b0, width_reg};
    assign too_long = dot_sat > {1'b0, width_reg};
    assign eol_ok   = zero_run_reg >= 4'(MIN_EOL_ZEROS);

    // Next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (acc && b)
                    phase_next = eol_ok ? PH_DECODE : PH_HALT;
            end
            PH_DECODE:
            begin
                if (acc)
                begin
                    if (!lk.match && !lk.live)
                        phase_next = PH_HALT;
                    else if (lk.match && line_end)
                        phase_next = too_long ? PH_HALT : PH_HUNT;
                end
            end
            PH_HALT: phase_next = PH_HALT;
            default: phase_next = PH_HALT;
        endcase
    end

    // Datapath and command
    always_comb
    begin
        zero_run_next = zero_run_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        black_next    = black_reg;
        dot_next      = dot_reg;
        line_next     = line_reg;
        push          = 1'b0;
        cmd           = '0;
        cmd.fail      = ERR_NONE;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (acc)
                begin
                    if (!b)
                    begin
                        if (zero_run_reg != 4'hF)
                            zero_run_next = zero_run_reg + 4'd1;
                    end
                    else
                    begin
                        push          = 1'b1;
                        zero_run_next = '0;
                        if (eol_ok)
                        begin
                            cmd.eol_count = 4'd1;
                            black_next    = 1'b0;
                            dot_next      = '0;
                            pos_next      = '0;
                            len_next      = '0;
                        end
                        else
                            cmd.fail = ERR_NO_EOL;
                    end
                end
            end
            PH_DECODE:
            begin
                if (acc)
                begin
                    push         = 1'b1;
                    cmd.has_bit  = 1'b1;
                    cmd.code_bit = b;
                    pos_next     = pos_step;
                    len_next     = len_step;
                    if (!lk.match && !lk.live)
                        cmd.fail = ERR_BAD_CODE;
                    else if (lk.match)
                    begin
                        dot_next = dot_sat;
                        pos_next = '0;
                        len_next = '0;
                        if (line_end)
                        begin
                            if (too_long)
                                cmd.fail = ERR_TOO_LONG;
                            else
                            begin
                                line_next     = line_inc;
                                zero_run_next = '0;
                                black_next    = 1'b0;
                                if (line_inc >= lines_reg)
                                begin
                                    cmd.eol_count = 4'(RTC_EOL_COUNT);
                                    cmd.pad       = 1'b1;
                                    line_next     = '0;
                                end
                            end
                        end
                        else if (is_term)
                            black_next = !black_reg;
                    end
                end
            end
            PH_HALT:
            begin
                push = 1'b0;
            end
            default:
            begin
                push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            zero_run_reg <= '0;
            pos_reg      <= '0;
            len_reg      <= '0;
            black_reg    <= 1'b0;
            dot_reg      <= '0;
            line_reg     <= '0;
            lines_reg    <= LINES_RESET;
            width_reg    <= WIDTH_RESET;
        end
        else
        begin
            phase_reg    <= phase_next;
            zero_run_reg <= zero_run_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            black_reg    <= black_next;
            dot_reg      <= dot_next;
            line_reg     <= line_next;
            if (cfg.valid && cfg.index == CFG_LINES_PER_PAGE)
                lines_reg <= cfg.data;
            if (cfg.valid && cfg.index == CFG_LINE_WIDTH)
                width_reg <= cfg.data;
        end
    end

endmodule

// File: rtl/core/mhr_queue.sv
module mhr_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  mhr_pkg::cmd_t push_cmd,
    input  logic          pop,
    output logic          full,
    output logic          empty,
    output mhr_pkg::cmd_t head
);
    import mhr_pkg::*;

    localparam int AW = $clog2(QDEPTH);

    cmd_t          mem [QDEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   count_reg, count_next;

    assign full  = count_reg == (AW+1)'(QDEPTH);
    assign empty = count_reg == '0;
    assign head  = mem[rd_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_reg + 1'b1;
            if (pop)
                rd_reg <= rd_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// File: rtl/core/mhr_back.sv
module mhr_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          empty,
    input  mhr_pkg::cmd_t head,
    output logic          pop,
    mhr_res_if.source     res
);
    import mhr_pkg::*;

    logic       started_reg, started_next;
    logic       bpend_reg, bpend_next;
    logic [6:0] rem_reg, rem_next;
    logic [3:0] ecnt_reg, ecnt_next;
    logic       stat_reg, stat_next;
    logic [7:0] shift_reg, shift_next;
    logic [2:0] fill_reg, fill_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, done_reg, last_reg;
    logic [1:0] err_reg;

    logic       eff_bpend, eff_stat;
    logic [6:0] eff_rem, rem_after;
    logic [3:0] eff_ecnt;
    logic       bit_avail, need_pad, need_stat, push_bit, pbit, byte_full;
    logic       emit, slot_free, go, finish, last;
    logic [2:0] fill_after;

    assign eff_bpend = started_reg ? bpend_reg : head.has_bit;
    assign eff_rem   = started_reg ? rem_reg
                                   : {6'd0, head.has_bit} + 7'(head.eol_count * EOL_BITS);
    assign eff_ecnt  = started_reg ? ecnt_reg : '0;
    assign eff_stat  = started_reg ? stat_reg : 1'b0;

    assign bit_avail  = eff_rem != '0;
    assign need_pad   = !bit_avail && head.pad && fill_reg != '0;
    assign need_stat  = !bit_avail && !need_pad && head.fail != ERR_NONE && !eff_stat;
    assign push_bit   = bit_avail || need_pad;
    assign pbit       = bit_avail && (eff_bpend ? head.code_bit : eff_ecnt == 4'(EOL_BITS - 1));
    assign byte_full  = push_bit && fill_reg == 3'd7;
    assign fill_after = byte_full ? 3'd0 : fill_reg + 3'd1;
    assign rem_after  = eff_rem - {6'd0, bit_avail};

    // A full byte ends the command's items unless more bytes, padding or a status follow.
    assign last = need_pad ||
                  (head.fail == ERR_NONE && rem_after < 7'd8 &&
                   !(head.pad && rem_after != '0));

    assign emit      = byte_full || need_stat;
    assign slot_free = !valid_reg || res.ready;
    assign go        = !empty && (!emit || slot_free);
    assign finish    = need_stat ||
                       !(push_bit && (rem_after != '0 || (head.pad && fill_after != '0) ||
                                      head.fail != ERR_NONE));
    assign pop       = go && finish;

    always_comb
    begin
        started_next = started_reg;
        bpend_next   = bpend_reg;
        rem_next     = rem_reg;
        ecnt_next    = ecnt_reg;
        stat_next    = stat_reg;
        shift_next   = shift_reg;
        fill_next    = fill_reg;
        if (go)
        begin
            started_next = !finish;
            bpend_next   = eff_bpend && !bit_avail;
            rem_next     = rem_after;
            stat_next    = eff_stat || need_stat;
            ecnt_next    = eff_ecnt;
            if (bit_avail && !eff_bpend)
                ecnt_next = (eff_ecnt == 4'(EOL_BITS - 1)) ? 4'd0 : eff_ecnt + 4'd1;
            if (push_bit)
            begin
                shift_next = {shift_reg[6:0], pbit};
                fill_next  = fill_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            bpend_reg   <= 1'b0;
            rem_reg     <= '0;
            ecnt_reg    <= '0;
            stat_reg    <= 1'b0;
            shift_reg   <= '0;
            fill_reg    <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            started_reg <= started_next;
            bpend_reg   <= bpend_next;
            rem_reg     <= rem_next;
            ecnt_reg    <= ecnt_next;
            stat_reg    <= stat_next;
            shift_reg   <= shift_next;
            fill_reg    <= fill_next;
            if (go && emit)
                valid_reg <= 1'b1;
            else if (res.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && emit)
        begin
            if (byte_full)
            begin
                byte_reg   <= {shift_reg[6:0], pbit};
                bvalid_reg <= 1'b1;
                done_reg   <= last && head.pad;
                err_reg    <= ERR_NONE;
                last_reg   <= last;
            end
            else
            begin
                byte_reg   <= '0;
                bvalid_reg <= 1'b0;
                done_reg   <= 1'b0;
                err_reg    <= head.fail;
                last_reg   <= 1'b1;
            end
        end
    end

    assign res.valid       = valid_reg;
    assign res.out_byte    = byte_reg;
    assign res.byte_valid  = bvalid_reg;
    assign res.page_done   = done_reg;
    assign res.error_code  = err_reg;
    assign res.last_of_run = last_reg;

endmodule

// File: rtl/core/mh_fax_line_reframer.sv
// A result item passes through the command queue and the registered output item
// after the input bit that completes it. Input: one coded bit per cycle while the queue
// is not full; the packer shifts out each 12-bit EOL and a page end with RTC bit by bit.
// Reset: rst_n is asynchronous, active low; control registers return to their defaults
// (output fields and queue storage are not reset), the queue empties and the block hunts for the first EOL.
module mh_fax_line_reframer (
    input  logic      clk,
    input  logic      rst_n,
    mhr_bit_if.sink   bits,
    mhr_cfg_if.sink   cfg,
    mhr_res_if.source results
);
    import mhr_pkg::*;

    // Front: EOL hunting, code table walk, run totals, line and page counts.
    // It turns each bit into at most one command for the packer.
    logic q_full, q_empty, push, pop;
    cmd_t cmd, head;

    mhr_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .bits   (bits),
        .cfg    (cfg),
        .q_full (q_full),
        .push   (push),
        .cmd    (cmd)
    );

    // Short queue: lets the front keep taking bits while the packer drains an EOL
    // or RTC, or while the output item waits.
    mhr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (cmd),
        .pop      (pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head)
    );

    // Back: shift bits into the byte packer one a cycle unless the output item waits, pad at page end,
    // issue status items, and hold the registered output item.
    mhr_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .empty (q_empty),
        .head  (head),
        .pop   (pop),
        .res   (results)
    );

endmodule

// File: test/mh_reframer_checker.sv
module mh_reframer_checker (
    input  logic      clk,
    input  logic      rst_n,
    mhr_bit_if        bits,
    mhr_cfg_if        cfg,
    mhr_res_if        results,
    output int        fail_count,
    output int        pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mhr_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       data_valid;
        logic       done;
        err_t       err;
        logic       last;
    } frame_item_t;

    frame_item_t expected_q[$];
    frame_item_t step_q[$];

    logic [11:0] lines_cfg;
    logic [11:0] width_cfg;
    phase_t      ph;
    int          zeros_seen;
    logic [12:0] code_pos;
    int          code_len;
    logic        is_black;
    int          dots;
    logic [11:0] line_cnt;
    logic [7:0]  shreg;
    int          shfill;

    task automatic emit(logic [7:0] d, logic v, err_t e);
        frame_item_t it;
        it.data = d;
        it.data_valid = v;
        it.done = 1'b0;
        it.err = e;
        it.last = 1'b0;
        if (step_q.size() < 10)
            step_q.push_back(it);
    endtask

    task automatic pack_bit(logic b);
        shreg = {shreg[6:0], b};
        shfill++;
        if (shfill >= 8)
        begin
            emit(shreg, 1'b1, ERR_NONE);
            shreg = '0;
            shfill = 0;
        end
    endtask

    task automatic pack_eol();
        repeat (11) pack_bit(1'b0);
        pack_bit(1'b1);
    endtask

    task automatic halt(err_t e);
        emit(8'd0, 1'b0, e);
        ph = PH_HALT;
    endtask

    // Run length on a full match, -1 while the prefix is live, -2 if invalid.
    function automatic int run_of_code(logic black, int len, logic [12:0] pos);
        logic [15:0] ent;
        int          elen;
        logic [12:0] ecode;
        bit          live;
        live = 0;
        if (len == 0 || len > MAX_CODE_LEN)
            return -2;
        for (int i = 0; i < ENTRIES; i++)
        begin
            ent = black ? BLACK_CODES[i] : WHITE_CODES[i];
            elen = int'(ent[11:8]);
            ecode = {5'd0, ent[7:0]};
            if (elen == len && ecode == pos)
            begin
                if (i < NUM_TERM)
                    return i;
                if (i < NUM_TERM + NUM_MAKEUP)
                    return (i - 63) * 64;
                return 1792 + (i - 91) * 64;
            end
            if (elen > len && (ecode >> (elen - len)) == pos)
                live = 1;
        end
        return live ? -1 : -2;
    endfunction

    task automatic decode_bit(logic b);
        int run;
        step_q.delete();
        if (ph == PH_HUNT)
        begin
            if (!b)
            begin
                if (zeros_seen < 15)
                    zeros_seen++;
            end
            else
            begin
                if (zeros_seen < MIN_EOL_ZEROS)
                    halt(ERR_NO_EOL);
                else
                begin
                    pack_eol();
                    ph = PH_DECODE;
                    is_black = 0;
                    dots = 0;
                    code_pos = '0;
                    code_len = 0;
                end
                zeros_seen = 0;
            end
        end
        else if (ph == PH_DECODE)
        begin
            pack_bit(b);
            code_pos = {code_pos[11:0], b};
            code_len++;
            run = run_of_code(is_black, code_len, code_pos);
            if (run == -2)
                halt(ERR_BAD_CODE);
            else if (run >= 0)
            begin
                dots = (dots + run > DOT_MAX) ? DOT_MAX : dots + run;
                code_pos = '0;
                code_len = 0;
                if (run < 64)
                begin
                    if (dots >= width_cfg)
                    begin
                        if (dots > width_cfg)
                            halt(ERR_TOO_LONG);
                        else
                        begin
                            line_cnt = line_cnt + 12'd1;
                            if (line_cnt >= lines_cfg)
                            begin
                                repeat (RTC_EOL_COUNT) pack_eol();
                                while (shfill != 0)
                                    pack_bit(1'b0);
                                if (step_q.size() > 0)
                                    step_q[step_q.size() - 1].done = 1'b1;
                                line_cnt = '0;
                            end
                            ph = PH_HUNT;
                            zeros_seen = 0;
                            is_black = 0;
                        end
                    end
                    else
                        is_black = ~is_black;
                end
            end
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        foreach (step_q[i])
            expected_q.push_back(step_q[i]);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_item_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            lines_cfg = LINES_RESET;
            width_cfg = WIDTH_RESET;
            ph = PH_HUNT;
            zeros_seen = 0;
            code_pos = '0;
            code_len = 0;
            is_black = 0;
            dots = 0;
            line_cnt = '0;
            shreg = '0;
            shfill = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == CFG_LINES_PER_PAGE)
                    lines_cfg = cfg.data;
                else if (cfg.index == CFG_LINE_WIDTH)
                    width_cfg = cfg.data;
            end
            if (bits.valid && bits.ready)
                decode_bit(bits.in_bit);
            if (results.valid && results.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result item byte=%02h bv=%0b pd=%0b err=%0d last=%0b",
                             $realtime, results.out_byte, results.byte_valid,
                             results.page_done, results.error_code, results.last_of_run);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (results.out_byte !== want.data || results.byte_valid !== want.data_valid
                        || results.page_done !== want.done || results.error_code !== want.err
                        || results.last_of_run !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: mismatch expected byte=%02h bv=%0b pd=%0b err=%0d last=%0b",
                                 $realtime, want.data, want.data_valid, want.done, want.err,
                                 want.last);
                        $display("%0t:          actual   byte=%02h bv=%0b pd=%0b err=%0d last=%0b",
                                 $realtime, results.out_byte, results.byte_valid,
                                 results.page_done, results.error_code, results.last_of_run);
                    end
                end
            end
        end
        pending = expected_q.size();
    end

endmodule

// File: test/tb_mh_fax_line_reframer.sv
module tb_mh_fax_line_reframer;
    timeunit 1ns;
    timeprecision 1ps;
    import mhr_pkg::*;

    localparam int STALL_LIMIT = 3000;  // cycles with no handshake at all
    localparam int SETTLE      = 120;   // packer drain after the last expected item
    localparam int HOLD_CYCLES = 300;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles;
    bit   tx_gaps;
    bit   rx_stalls;
    bit   rx_hold_req;
    int   cur_width;
    int   sent;

    mhr_bit_if bits ();
    mhr_cfg_if cfg ();
    mhr_res_if results ();

    mh_fax_line_reframer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .bits    (bits),
        .cfg     (cfg),
        .results (results)
    );

    mh_reframer_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .bits       (bits),
        .cfg        (cfg),
        .results    (results),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: end the run if no channel moves an item for too long.
    always @(posedge clk)
    begin
        if ((bits.valid && bits.ready) || (cfg.valid && cfg.ready)
            || (results.valid && results.ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold_req)
            begin
                results.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold_req = 0;
                results.ready <= 1'b1;
            end
            else if (rx_stalls && $urandom_range(0, 9) == 0)
            begin
                results.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                results.ready <= 1'b1;
            end
            else
                results.ready <= 1'b1;
        end
    end

    // Offer one coded bit; hold it until accepted, return at a falling edge.
    task automatic put_bit(logic b);
        if (tx_gaps && $urandom_range(0, 11) == 0)
        begin
            bits.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        bits.valid  <= 1'b1;
        bits.in_bit <= b;
        @(posedge clk);
        while (!bits.ready)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_code(logic black, int idx);
        logic [15:0] ent;
        logic [12:0] code;
        ent  = black ? BLACK_CODES[idx] : WHITE_CODES[idx];
        code = {5'd0, ent[7:0]};
        for (int i = int'(ent[11:8]) - 1; i >= 0; i--)
            put_bit(code[i]);
    endtask

    // Encode a run as make-up codes followed by one terminating code.
    task automatic send_run(logic black, int run);
        int m;
        while (run >= 64)
        begin
            m = (run > 2560) ? 2560 : (run / 64) * 64;
            send_code(black, (m <= 1728) ? 63 + m / 64 : 91 + (m - 1792) / 64);
            run -= m;
        end
        send_code(black, run);
    endtask

    task automatic send_eol(int fill);
        repeat (fill) put_bit(1'b0);
        put_bit(1'b1);
    endtask

    // One well-formed line: EOL with fill, then runs that total the width exactly.
    task automatic send_line(int fill);
        int   left;
        int   r;
        logic black;
        send_eol(fill);
        left  = cur_width;
        black = 1'b0;
        while (left > 0)
        begin
            if ($urandom_range(0, 3) == 0)
                r = $urandom_range(0, left);
            else
                r = $urandom_range(0, (left < 8) ? left : 8);
            send_run(black, r);
            left -= r;
            black = ~black;
        end
    endtask

    // Drop valid and wait until every expected item is out and the packer is drained.
    task automatic quiesce();
        bits.valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value[11:0];
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        if (idx == CFG_LINE_WIDTH)
            cur_width = value;
    endtask

    task automatic set_page(int lines, int width);
        quiesce();
        write_reg(CFG_LINES_PER_PAGE, lines);
        write_reg(CFG_LINE_WIDTH, width);
    endtask

    initial
    begin
        int phase_no;
        int w;
        bits.valid  = 1'b0;
        bits.in_bit = 1'b0;
        cfg.valid   = 1'b0;
        cfg.index   = CFG_LINES_PER_PAGE;
        cfg.data    = '0;
        rst_n       = 1'b0;
        tx_gaps     = 1;
        rx_stalls   = 1;
        rx_hold_req = 0;
        cur_width   = WIDTH_RESET;
        sent        = 0;
        idle_cycles = 0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: smallest page and width, exact minimum fill, long saturating fill.
        set_page(1, 1);
        send_line(MIN_EOL_ZEROS);
        send_eol(20);
        send_code(1'b0, 1);
        // Widest line, made of extended and ordinary make-up codes, two lines per page.
        set_page(2, 4095);
        send_eol(12);
        send_run(1'b0, 4095 - 63);
        send_run(1'b1, 63);
        set_page(4095, 1);
        send_line(11);
        // Close the page with a line of the black terminating codes for the shortest runs.
        set_page(3, 6);
        send_eol(13);
        for (int i = 0; i < 4; i++)
        begin
            send_code(1'b0, 0);
            send_code(1'b1, i);
        end

        // Random pages; one phase holds the receiver off, one pauses the sender.
        phase_no = 0;
        while (phase_no < 7)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            set_page($urandom_range(1, 2), w);
            if (phase_no == 2)
                rx_hold_req = 1;
            repeat ((phase_no == 2) ? 3 : 1) send_line($urandom_range(11, 18));
            if (phase_no == 4)
                quiesce();
            if (phase_no >= 4)
            begin
                tx_gaps   = 0;
                rx_stalls = 0;
            end
            phase_no++;
        end

        // Finish with one error, which halts the block; later bits are ignored.
        set_page(1, $urandom_range(1, 30));
        case ($urandom_range(0, 2))
            0: send_eol($urandom_range(0, MIN_EOL_ZEROS - 1));
            1:
            begin
                send_eol(11);
                repeat (14) put_bit(1'b0);
            end
            default:
            begin
                send_eol(11);
                send_run(1'b0, cur_width + $urandom_range(1, 70));
            end
        endcase
        repeat (8) put_bit($urandom_range(0, 1));

        quiesce();
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mhr_pkg.sv
rtl/core/mhr_if.sv
rtl/core/mhr_front.sv
rtl/core/mhr_queue.sv
rtl/core/mhr_back.sv
rtl/core/mh_fax_line_reframer.sv
test/mh_reframer_checker.sv
test/tb_mh_fax_line_reframer.sv
